>>> rtl/mkt_pkg.sv
// ----------------------------------------------------------------------------
// Morse keyer timing package
// Character codes, register indexes and the Morse letter table.
// ----------------------------------------------------------------------------
package mkt_pkg;

  localparam int unsigned DurW  = 20;
  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] REG_DOT   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_DASH  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_GAP   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_SPACE = 8'd3;

  localparam logic [DurW-1:0] DOT_RESET   = 20'd4410;
  localparam logic [DurW-1:0] DASH_RESET  = 20'd8820;
  localparam logic [DurW-1:0] GAP_RESET   = 20'd2205;
  localparam logic [DurW-1:0] SPACE_RESET = 20'd11025;

  localparam logic [CharW-1:0] CH_SPACE   = 8'h20;
  localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CharW-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;
  localparam logic [CharW-1:0] CASE_DIFF  = 8'h20;

  // Element i of a letter sits in bit i of code; a set bit is a dash.
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] code;
  } letter_t;

  function automatic letter_t letter_lookup(input logic [4:0] idx);
    letter_t e;
    unique case (idx)
      5'd0:  e = '{3'd2, 4'b0010};
      5'd1:  e = '{3'd4, 4'b0001};
      5'd2:  e = '{3'd4, 4'b0101};
      5'd3:  e = '{3'd3, 4'b0001};
      5'd4:  e = '{3'd1, 4'b0000};
      5'd5:  e = '{3'd4, 4'b0100};
      5'd6:  e = '{3'd3, 4'b0011};
      5'd7:  e = '{3'd4, 4'b0000};
      5'd8:  e = '{3'd2, 4'b0000};
      5'd9:  e = '{3'd4, 4'b1110};
      5'd10: e = '{3'd3, 4'b0101};
      5'd11: e = '{3'd4, 4'b0010};
      5'd12: e = '{3'd2, 4'b0011};
      5'd13: e = '{3'd2, 4'b0001};
      5'd14: e = '{3'd3, 4'b0111};
      5'd15: e = '{3'd4, 4'b0110};
      5'd16: e = '{3'd4, 4'b1011};
      5'd17: e = '{3'd3, 4'b0010};
      5'd18: e = '{3'd3, 4'b0000};
      5'd19: e = '{3'd1, 4'b0001};
      5'd20: e = '{3'd3, 4'b0100};
      5'd21: e = '{3'd4, 4'b1000};
      5'd22: e = '{3'd3, 4'b0110};
      5'd23: e = '{3'd4, 4'b1001};
      5'd24: e = '{3'd4, 4'b1101};
      5'd25: e = '{3'd4, 4'b0011};
      default: e = '{3'd0, 4'b0000};
    endcase
    return e;
  endfunction

endpackage

>>> rtl/morse_keyer_timing.sv
// ----------------------------------------------------------------------------
// Morse keyer timing generator
// Turns one ASCII character into a run of key-on and key-off segments.
// ----------------------------------------------------------------------------
// The accepted character sets the state register; its first segment is then
// registered at the output. Throughput: a small sequencer drives one segment
// selector, one segment per cycle unless the output side stalls; a letter of
// n elements gives 2n+1 segments, a space 2 and an unknown character 1.
// Reset: the sequencer goes idle, the output is empty and the four timing
// registers return to their default values.
module morse_keyer_timing
  import mkt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CharW-1:0]    char_code_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                key_on_o,
  output logic [DurW-1:0]     duration_o,
  output logic                bad_char_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DurW-1:0]     cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LETTER = 4'b0010,
    ST_WORD   = 4'b0100,
    ST_BAD    = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        seg_q, seg_d;
  letter_t           letter_q, letter_d;
  logic [DurW-1:0]   dot_q, dash_q, gap_q, space_q;

  logic              out_valid_q, out_valid_d;
  logic              key_on_q, key_on_d;
  logic [DurW-1:0]   duration_q, duration_d;
  logic              bad_char_q, bad_char_d;
  logic              last_q, last_d;

  logic              in_fire;
  logic              emit;
  logic [CharW-1:0]  char_up;
  logic [CharW-1:0]  letter_off;
  logic              seg_key_on;
  logic [DurW-1:0]   seg_dur;
  logic              seg_bad;
  logic              seg_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign emit        = (state_q != ST_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    char_up = char_code_i;
    if (char_code_i >= CH_LOWER_A && char_code_i <= CH_LOWER_Z) begin
      char_up = char_code_i - CASE_DIFF;
    end
    letter_off = char_up - CH_UPPER_A;
  end

  // Segment selector shared by every step of the sequence.
  always_comb begin
    seg_key_on = 1'b0;
    seg_dur    = space_q;
    seg_bad    = 1'b0;
    seg_last   = 1'b0;
    unique case (state_q)
      ST_LETTER: begin
        if (seg_q == {letter_q.len, 1'b0}) begin
          seg_last = 1'b1;
        end else if (!seg_q[0]) begin
          seg_key_on = 1'b1;
          seg_dur    = letter_q.code[seg_q[2:1]] ? dash_q : dot_q;
        end else begin
          seg_dur = gap_q;
        end
      end
      ST_WORD: begin
        seg_last = seg_q[0];
      end
      ST_BAD: begin
        seg_dur  = '0;
        seg_bad  = 1'b1;
        seg_last = 1'b1;
      end
      default: begin
        seg_dur = space_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    seg_d    = seg_q;
    letter_d = letter_q;
    if (in_fire) begin
      seg_d    = '0;
      letter_d = letter_lookup(letter_off[4:0]);
      if (char_up == CH_SPACE) begin
        state_d = ST_WORD;
      end else if (char_up >= CH_UPPER_A && char_up <= CH_UPPER_Z) begin
        state_d = ST_LETTER;
      end else begin
        state_d = ST_BAD;
      end
    end else if (emit) begin
      if (seg_last) begin
        state_d = ST_IDLE;
      end else begin
        seg_d = seg_q + 4'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    key_on_d    = key_on_q;
    duration_d  = duration_q;
    bad_char_d  = bad_char_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      key_on_d    = seg_key_on;
      duration_d  = seg_dur;
      bad_char_d  = seg_bad;
      last_d      = seg_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= '0;
      out_valid_q <= 1'b0;
      dot_q       <= DOT_RESET;
      dash_q      <= DASH_RESET;
      gap_q       <= GAP_RESET;
      space_q     <= SPACE_RESET;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_DOT:   dot_q   <= cfg_data_i;
          REG_DASH:  dash_q  <= cfg_data_i;
          REG_GAP:   gap_q   <= cfg_data_i;
          REG_SPACE: space_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    letter_q   <= letter_d;
    key_on_q   <= key_on_d;
    duration_q <= duration_d;
    bad_char_q <= bad_char_d;
    last_q     <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign key_on_o    = key_on_q;
  assign duration_o  = duration_q;
  assign bad_char_o  = bad_char_q;
  assign last_o      = last_q;

  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_char_o |-> last_o && !key_on_o && (duration_o == '0))
    else $error("bad character transaction is not a single empty segment");

  a_on_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_on_o |-> !last_o)
    else $error("key-on segment marked as last");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted transaction");

endmodule

>>> tb/sv/tb_morse_keyer_timing.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse keyer timing testbench
// Sends ASCII characters through the keyer under several register settings
// and handshake patterns. Every segment that comes out is checked against a
// segment list predicted from the Morse table and the current timing values.
// ----------------------------------------------------------------------------
module tb_morse_keyer_timing;
  import mkt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_LO = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_UNUSED_HI = 8'hFF;
  localparam logic [DurW-1:0] DUR_MAX = 20'hFFFFF;

  typedef struct packed {
    logic            key_on;
    logic [DurW-1:0] duration;
    logic            bad_char;
    logic            last;
  } seg_t;

  class keying_tracker;
    logic [DurW-1:0] dot_len, dash_len, gap_len, space_len;
    string           morse_tab [26];
    seg_t            segments_due [$];
    int unsigned     errors, chars_seen, bad_chars, segs_checked, reg_writes;

    function new();
      dot_len   = DOT_RESET;
      dash_len  = DASH_RESET;
      gap_len   = GAP_RESET;
      space_len = SPACE_RESET;
      morse_tab = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                    "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                    "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                    "-.--", "--.."};
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
      reg_writes++;
      case (idx)
        REG_DOT:   dot_len = val;
        REG_DASH:  dash_len = val;
        REG_GAP:   gap_len = val;
        REG_SPACE: space_len = val;
        default: ;
      endcase
    endfunction

    function void add_segment(input logic on, input logic [DurW-1:0] dur, input logic bad);
      seg_t s;
      s.key_on   = on;
      s.duration = dur;
      s.bad_char = bad;
      s.last     = 1'b0;
      segments_due.push_back(s);
    endfunction

    function void expand_char(input logic [CharW-1:0] c);
      logic [CharW-1:0] ch;
      string            code;
      ch = c;
      chars_seen++;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_DIFF;
      if (ch == CH_SPACE) begin
        add_segment(1'b0, space_len, 1'b0);
        add_segment(1'b0, space_len, 1'b0);
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
        code = morse_tab[ch - CH_UPPER_A];
        for (int k = 0; k < code.len(); k++) begin
          add_segment(1'b1, (code[k] == "-") ? dash_len : dot_len, 1'b0);
          add_segment(1'b0, gap_len, 1'b0);
        end
        add_segment(1'b0, space_len, 1'b0);
      end else begin
        bad_chars++;
        add_segment(1'b0, '0, 1'b1);
      end
      segments_due[segments_due.size() - 1].last = 1'b1;
    endfunction

    function void check_segment(input logic on, input logic [DurW-1:0] dur,
                                input logic bad, input logic lst);
      seg_t want;
      if (segments_due.size() == 0) begin
        $error("unexpected segment: key_on=%0b duration=%0d bad_char=%0b last=%0b",
               on, dur, bad, lst);
        errors++;
        return;
      end
      want = segments_due.pop_front();
      segs_checked++;
      if (on !== want.key_on) begin
        $error("key_on: expected %0b, got %0b", want.key_on, on);
        errors++;
      end
      if (dur !== want.duration) begin
        $error("duration: expected %0d, got %0d", want.duration, dur);
        errors++;
      end
      if (bad !== want.bad_char) begin
        $error("bad_char: expected %0b, got %0b", want.bad_char, bad);
        errors++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic [CharW-1:0]   char_code = '0;
  logic               out_ready = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DurW-1:0]    cfg_data = '0;
  logic               in_ready_o, out_valid_o, key_on_o, bad_char_o, last_o, cfg_ready_o;
  logic [DurW-1:0]    duration_o;

  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        hold_request = 0;
  int unsigned        hold_left = 0;
  int unsigned        quiet = 0;
  keying_tracker      trk;

  morse_keyer_timing dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .key_on_o    (key_on_o),
    .duration_o  (duration_o),
    .bad_char_o  (bad_char_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) trk.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready_o) trk.expand_char(char_code);
      if (out_valid_o && out_ready)
        trk.check_segment(key_on_o, duration_o, bad_char_o, last_o);
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("morse_keyer_timing test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_char(input logic [CharW-1:0] c);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    int unsigned      r;
    logic [CharW-1:0] c;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 60) begin
        c = CH_UPPER_A + CharW'($urandom_range(25));
        if ($urandom_range(1)) c = c + CASE_DIFF;
      end else if (r < 75) begin
        c = CH_SPACE;
      end else begin
        c = CharW'($urandom_range(255));
      end
      send_char(c);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (trk.segments_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [CharW-1:0] directed [$];
    trk = new();
    directed = '{"A", "Z", "a", "z", "V", "Q", "J", "E", "T", "H", " ", 8'h00, 8'hFF,
                 8'h80, 8'h7F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h1F, 8'h21, "0", "?"};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    foreach (directed[i]) send_char(directed[i]);
    drain();

    write_reg(REG_DOT, DUR_MAX);
    write_reg(REG_DASH, DUR_MAX);
    write_reg(REG_GAP, DUR_MAX);
    write_reg(REG_SPACE, DUR_MAX);
    write_reg(REG_UNUSED_LO, '0);
    write_reg(REG_UNUSED_HI, DUR_MAX);
    idle_pct = 88;
    send_random(85);
    drain();

    write_reg(REG_DOT, '0);
    write_reg(REG_DASH, '0);
    write_reg(REG_GAP, '0);
    write_reg(REG_SPACE, '0);
    write_reg(CfgIdxW'($urandom_range(4, 255)), DurW'($urandom));
    idle_pct = 0;
    stall_pct = 88;
    send_random(85);
    drain();

    write_reg(REG_DOT, DurW'($urandom_range(1, DUR_MAX)));
    write_reg(REG_DASH, DurW'($urandom_range(1, DUR_MAX)));
    write_reg(REG_GAP, DurW'($urandom_range(0, DUR_MAX)));
    write_reg(REG_SPACE, DurW'($urandom_range(0, DUR_MAX)));
    idle_pct = 8;
    stall_pct = 8;
    send_random(85);
    drain();

    write_reg(REG_DOT, 20'd1);
    write_reg(REG_DASH, 20'd3);
    write_reg(REG_GAP, 20'd1);
    write_reg(REG_SPACE, 20'd7);
    idle_pct = 0;
    stall_pct = 0;
    hold_request = HOLD_CYCLES;
    send_random(40);
    drain();
    send_random(45);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (trk.segments_due.size() != 0) begin
      $error("%0d expected segments never arrived", trk.segments_due.size());
      trk.errors += trk.segments_due.size();
    end
    $display("Sent %0d characters (%0d outside the table) over %0d register writes,",
             trk.chars_seen, trk.bad_chars, trk.reg_writes);
    $display("and checked %0d key segments under five timing settings.", trk.segs_checked);
    if (trk.errors == 0) begin
      $display("morse_keyer_timing test passed");
    end else begin
      $display("morse_keyer_timing test failed");
    end
    $finish;
  end

endmodule
